// File: rtl/pwi_pkg.sv
// Shared constants, types and helpers for the pixel window interpolator.
`timescale 1ns / 1ps
package pwi_pkg;
  localparam int FRAC_BITS  = 12;
  localparam int PIXEL_BITS = 16;
  localparam int LANE_BITS  = 16;
  localparam int ROW_BITS   = 64;
  localparam int MASK_BITS  = 16;
  localparam int FIELD_FRAC = 12;
  localparam int WT_BITS    = FRAC_BITS + 3;
  localparam int PROD_BITS  = PIXEL_BITS + WT_BITS;
  localparam int HSUM_BITS  = PROD_BITS + 2;
  localparam int ACC_BITS   = HSUM_BITS + WT_BITS + 2;

  localparam logic [1:0] MODE_UNSET    = 2'd0;
  localparam logic [1:0] MODE_NEAREST  = 2'd1;
  localparam logic [1:0] MODE_BILINEAR = 2'd2;
  localparam logic [1:0] MODE_CUBIC    = 2'd3;

  localparam logic [1:0] USED_NEAREST  = 2'd0;
  localparam logic [1:0] USED_BILINEAR = 2'd1;
  localparam logic [1:0] USED_CUBIC    = 2'd2;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  typedef logic signed [WT_BITS-1:0] wt_t;

  // Selected path for an item.
  typedef struct packed {
    logic       err;
    logic       direct;
    logic       spec;
    logic [1:0] used;
    pix_t       pix;
  } ctl_t;

  function automatic pix_t lane_pix(input logic [LANE_BITS-1:0] lane);
    return pix_t'(lane[PIXEL_BITS-1:0]);
  endfunction

  // Keys a=-1 weights from a, r = S-a and their squares, Q.3F rounded half up
  // to Q.F. Arithmetic shift = floor.
  function automatic wt_t cubic_w(input logic [FRAC_BITS-1:0] a,
                                  input logic [FRAC_BITS:0] r,
                                  input logic [2*FRAC_BITS-1:0] a2,
                                  input logic [2*FRAC_BITS:0] r2,
                                  input logic [1:0] k);
    logic signed [3*FRAC_BITS+4:0] ae, re, a2e, r2e, e;
    begin
      ae  = $signed({{(2*FRAC_BITS+5){1'b0}}, a});
      re  = $signed({{(2*FRAC_BITS+4){1'b0}}, r});
      a2e = $signed({{(FRAC_BITS+5){1'b0}}, a2});
      r2e = $signed({{(FRAC_BITS+4){1'b0}}, r2});
      case (k)
        2'd0:    e = -(ae * r2e);
        2'd1:    e = ((3*FRAC_BITS+5)'(1) <<< (3*FRAC_BITS)) - (a2e <<< (FRAC_BITS+1))
                     + ae * a2e;
        2'd2:    e = ae * (((3*FRAC_BITS+5)'(1) <<< (2*FRAC_BITS)) + (ae <<< FRAC_BITS)
                     - a2e);
        default: e = -(a2e * re);
      endcase
      e = e + ((3*FRAC_BITS+5)'(1) <<< (2*FRAC_BITS-1));
      e = e >>> (2*FRAC_BITS);
      return wt_t'(e);
    end
  endfunction
endpackage

// File: rtl/pwi_if.sv
// Valid/ready channel interfaces for the pixel window interpolator.
`timescale 1ns / 1ps
interface pwi_in_if;
  logic                         valid;
  logic                         ready;
  logic [pwi_pkg::ROW_BITS-1:0] row_zero;
  logic [pwi_pkg::ROW_BITS-1:0] row_one;
  logic [pwi_pkg::ROW_BITS-1:0] row_two;
  logic [pwi_pkg::ROW_BITS-1:0] row_three;
  logic [pwi_pkg::MASK_BITS-1:0] special_mask;
  logic [pwi_pkg::FIELD_FRAC-1:0] samp_frac;
  logic [pwi_pkg::FIELD_FRAC-1:0] line_frac;
  modport source (output valid, row_zero, row_one, row_two, row_three, special_mask,
                  samp_frac, line_frac, input ready);
  modport sink (input valid, row_zero, row_one, row_two, row_three, special_mask,
                samp_frac, line_frac, output ready);
endinterface

interface pwi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic               value_special;
  logic [1:0]         used_mode;
  logic               mode_error;
  modport source (output valid, value, value_special, used_mode, mode_error, input ready);
  modport sink (input valid, value, value_special, used_mode, mode_error, output ready);
endinterface

interface pwi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/pixel_window_interpolator_core.sv
// Top level of the pipelined pixel window interpolator.
//   channel | dir | transaction
//   in      | in  | window rows, special mask, sample and line fractions
//   out     | out | value, value_special, used_mode, mode_error
//   cfg     | in  | mode register write
// Five register stages: fraction squares and path select, weights, pixel
// products, row sums times line weights, rounding and output.
// One transaction per cycle; out valid rises when the item reaches the stage 5 register.
// All stages advance together when the output register is empty or taken,
// otherwise the whole pipeline holds.
// Synchronous active-low reset clears valid bits and mode to unset.
`timescale 1ns / 1ps
module pixel_window_interpolator_core (
  input  logic clk,
  input  logic rst_n,
  pwi_in_if.sink    in_ch,
  pwi_out_if.source out_ch,
  pwi_cfg_if.sink   cfg_ch
);
  localparam int F = pwi_pkg::FRAC_BITS;
  localparam int AB = pwi_pkg::ACC_BITS;

  logic [1:0] mode_r;
  logic       adv;
  logic       v1_r, v2_r, v3_r, v4_r, v5_r;

  assign adv = !v5_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pwi_pkg::MODE_UNSET;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.data;
    end
  end

  // stage 0 combinational
  pwi_pkg::pix_t  px [16];
  logic [F-1:0]   fa, fb;
  logic [15:0]    msk;
  logic [3:0]     bm;
  pwi_pkg::pix_t  bp [4];
  pwi_pkg::pix_t  pa_nxt [16];
  pwi_pkg::ctl_t  ctl_nxt;
  logic [1:0]     k;
  logic           use_cubic;
  logic [F:0]     ra_nxt, rb_nxt;
  logic [2*F-1:0] fa_sq_nxt, fb_sq_nxt;
  logic [2*F:0]   ra_sq_nxt, rb_sq_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i]      = pwi_pkg::lane_pix(in_ch.row_zero[16*i +: 16]);
      px[4 + i]  = pwi_pkg::lane_pix(in_ch.row_one[16*i +: 16]);
      px[8 + i]  = pwi_pkg::lane_pix(in_ch.row_two[16*i +: 16]);
      px[12 + i] = pwi_pkg::lane_pix(in_ch.row_three[16*i +: 16]);
    end
    fa  = in_ch.samp_frac[F-1:0];
    fb  = in_ch.line_frac[F-1:0];
    msk = in_ch.special_mask;
    if (mode_r == pwi_pkg::MODE_CUBIC) begin
      bp[0] = px[5]; bp[1] = px[6]; bp[2] = px[9]; bp[3] = px[10];
      bm = {msk[10:9], msk[6:5]};
    end else begin
      bp[0] = px[0]; bp[1] = px[1]; bp[2] = px[2]; bp[3] = px[3];
      bm = msk[3:0];
    end
    k = {fb[F-1], fa[F-1]};
    use_cubic = (mode_r == pwi_pkg::MODE_CUBIC) && (msk == '0);
    ctl_nxt = '0;
    case (mode_r)
      pwi_pkg::MODE_UNSET: begin
        ctl_nxt.err = 1'b1;
        ctl_nxt.direct = 1'b1;
      end
      pwi_pkg::MODE_NEAREST: begin
        ctl_nxt.direct = 1'b1;
        ctl_nxt.pix = px[0];
        ctl_nxt.spec = msk[0];
      end
      default: begin
        if (use_cubic) begin
          ctl_nxt.used = pwi_pkg::USED_CUBIC;
        end else if (bm != 4'd0) begin
          ctl_nxt.direct = 1'b1;
          ctl_nxt.pix = bp[k];
          ctl_nxt.spec = bm[k];
        end else begin
          ctl_nxt.used = pwi_pkg::USED_BILINEAR;
        end
      end
    endcase
    // bilinear places its four pixels at taps 0,1 of rows 0,1
    for (int i = 0; i < 16; i++) begin
      pa_nxt[i] = use_cubic ? px[i] : '0;
    end
    if (!use_cubic) begin
      pa_nxt[0] = bp[0]; pa_nxt[1] = bp[1]; pa_nxt[4] = bp[2]; pa_nxt[5] = bp[3];
    end
    ra_nxt = ((F+1)'(1) << F) - {1'b0, fa};
    rb_nxt = ((F+1)'(1) << F) - {1'b0, fb};
    fa_sq_nxt = (2*F)'(fa) * (2*F)'(fa);
    fb_sq_nxt = (2*F)'(fb) * (2*F)'(fb);
    ra_sq_nxt = (2*F+1)'(ra_nxt) * (2*F+1)'(ra_nxt);
    rb_sq_nxt = (2*F+1)'(rb_nxt) * (2*F+1)'(rb_nxt);
  end

  // stage 1 registers
  pwi_pkg::pix_t  p1_r [16];
  pwi_pkg::ctl_t  c1_r, c2_r, c3_r, c4_r;
  logic           cub1_r;
  logic [F-1:0]   fa1_r, fb1_r;
  logic [F:0]     ra1_r, rb1_r;
  logic [2*F-1:0] fa_sq1_r, fb_sq1_r;
  logic [2*F:0]   ra_sq1_r, rb_sq1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r     <= ctl_nxt;
      p1_r     <= pa_nxt;
      cub1_r   <= use_cubic;
      fa1_r    <= fa;
      fb1_r    <= fb;
      ra1_r    <= ra_nxt;
      rb1_r    <= rb_nxt;
      fa_sq1_r <= fa_sq_nxt;
      fb_sq1_r <= fb_sq_nxt;
      ra_sq1_r <= ra_sq_nxt;
      rb_sq1_r <= rb_sq_nxt;
    end
  end

  // stage 2: weights
  pwi_pkg::wt_t  wa_nxt [4], wb_nxt [4];
  pwi_pkg::pix_t p2_r [16];
  pwi_pkg::wt_t  wa2_r [4], wb2_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (cub1_r) begin
        wa_nxt[i] = pwi_pkg::cubic_w(fa1_r, ra1_r, fa_sq1_r, ra_sq1_r, 2'(i));
        wb_nxt[i] = pwi_pkg::cubic_w(fb1_r, rb1_r, fb_sq1_r, rb_sq1_r, 2'(i));
      end else begin
        wa_nxt[i] = '0;
        wb_nxt[i] = '0;
      end
    end
    if (!cub1_r) begin
      wa_nxt[0] = pwi_pkg::wt_t'({1'b0, ra1_r});
      wa_nxt[1] = pwi_pkg::wt_t'({1'b0, fa1_r});
      wb_nxt[0] = pwi_pkg::wt_t'({1'b0, rb1_r});
      wb_nxt[1] = pwi_pkg::wt_t'({1'b0, fb1_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r  <= c1_r;
      p2_r  <= p1_r;
      wa2_r <= wa_nxt;
      wb2_r <= wb_nxt;
    end
  end

  // stage 3: products
  logic signed [pwi_pkg::PROD_BITS-1:0] pr3_r [16];
  pwi_pkg::wt_t wb3_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r <= c2_r;
      wb3_r <= wb2_r;
      for (int i = 0; i < 16; i++) begin
        pr3_r[i] <= p2_r[i] * wa2_r[i % 4];
      end
    end
  end

  // stage 4: row sums times line weights
  logic signed [pwi_pkg::HSUM_BITS-1:0] h [4];
  logic signed [AB-1:0] rp4_r [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      h[r] = pwi_pkg::HSUM_BITS'(pr3_r[4*r]) + pwi_pkg::HSUM_BITS'(pr3_r[4*r+1])
           + pwi_pkg::HSUM_BITS'(pr3_r[4*r+2]) + pwi_pkg::HSUM_BITS'(pr3_r[4*r+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c4_r <= c3_r;
      for (int r = 0; r < 4; r++) begin
        rp4_r[r] <= AB'(h[r]) * AB'(wb3_r[r]);
      end
    end
  end

  // stage 5: sum, round, saturate, or pass a direct pixel
  logic signed [AB-1:0] acc, rnd;
  logic signed [15:0]   val_nxt;
  localparam logic signed [AB-1:0] PMAX = AB'((1 << (pwi_pkg::PIXEL_BITS-1)) - 1);
  localparam logic signed [AB-1:0] PMIN = -AB'(1 << (pwi_pkg::PIXEL_BITS-1));

  always_comb begin
    acc = rp4_r[0] + rp4_r[1] + rp4_r[2] + rp4_r[3];
    rnd = (acc + (AB'(1) <<< (2*F-1))) >>> (2*F);
    if (c4_r.direct) begin
      val_nxt = 16'(c4_r.pix);
    end else if (rnd > PMAX) begin
      val_nxt = 16'(PMAX);
    end else if (rnd < PMIN) begin
      val_nxt = 16'(PMIN);
    end else begin
      val_nxt = 16'(rnd);
    end
  end

  logic signed [15:0] val5_r;
  logic               spec5_r, err5_r;
  logic [1:0]         used5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val5_r  <= val_nxt;
      spec5_r <= c4_r.spec;
      used5_r <= c4_r.used;
      err5_r  <= c4_r.err;
    end
  end

  assign out_ch.valid         = v5_r;
  assign out_ch.value         = val5_r;
  assign out_ch.value_special = spec5_r;
  assign out_ch.used_mode     = used5_r;
  assign out_ch.mode_error    = err5_r;
endmodule

// File: rtl/pwi_checker.sv
// Port-level assertions for the pixel window interpolator, bound to the top level.
`timescale 1ns / 1ps
module pwi_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] out_value,
  input logic out_special,
  input logic [1:0] out_used,
  input logic out_err
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_value == 16'sd0 && !out_special
      && out_used == pwi_pkg::USED_NEAREST)
    else $error("error result not clean");
  a_spec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_special |-> out_used == pwi_pkg::USED_NEAREST)
    else $error("special flag on blended result");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used <= pwi_pkg::USED_CUBIC)
    else $error("bad used mode");
endmodule

bind pixel_window_interpolator_core pwi_checker u_pwi_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_value(out_ch.value), .out_special(out_ch.value_special),
  .out_used(out_ch.used_mode), .out_err(out_ch.mode_error)
);
